@@ design/ffa_pkg.sv @@
// ============================================================================
// ffa_pkg: shared types and constants for the first-fit allocator
// request and result layouts, node table entry, command and status codes
// ============================================================================
package ffa_pkg;

    // default node table depth
    localparam int NODES_DEFAULT = 128;

    // per-node capacities
    localparam int CORE_CAPACITY   = 24;
    localparam int MEMORY_CAPACITY = 64;

    // field widths
    localparam int CORE_W      = 5;
    localparam int MEM_W       = 7;
    localparam int NODE_FIELD_W = 7;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    // command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic                    cmd;
        logic [NODE_FIELD_W-1:0] target_node;
        logic [CORE_W-1:0]       cores_wanted;
        logic [MEM_W-1:0]        memory_wanted;
    } alloc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [NODE_FIELD_W-1:0] chosen_node;
        logic [CORE_W-1:0]       cores_left;
        logic [MEM_W-1:0]        memory_left;
    } alloc_rsp_t;

    // one node table entry
    typedef struct packed {
        logic [CORE_W-1:0] cores;
        logic [MEM_W-1:0]  memory;
    } ffa_entry_t;

    localparam int ENTRY_W = CORE_W + MEM_W;

    // shared unit result
    typedef struct packed {
        logic       fit;
        ffa_entry_t entry;
    } ffa_alu_out_t;

endpackage

@@ design/ffa_ram.sv @@
// ============================================================================
// ffa_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ============================================================================
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ffa_alu.sv @@
// ============================================================================
// ffa_alu: shared compare and update unit
// fit test and subtract for allocate, saturating add for release
// ============================================================================
module ffa_alu
    import ffa_pkg::*;
(
    input  ffa_entry_t        entry,
    input  logic              release_op,
    input  logic [CORE_W-1:0] cores,
    input  logic [MEM_W-1:0]  memory,
    output ffa_alu_out_t      result
);

    logic [CORE_W:0] core_sum;
    logic [MEM_W:0]  mem_sum;

    always_comb
    begin
        core_sum = {1'b0, entry.cores} + {1'b0, cores};
        mem_sum  = {1'b0, entry.memory} + {1'b0, memory};
        result.fit = (entry.cores >= cores) && (entry.memory >= memory);
        if (release_op)
        begin
            result.entry.cores  = (core_sum > (CORE_W+1)'(CORE_CAPACITY))
                                ? CORE_W'(CORE_CAPACITY) : core_sum[CORE_W-1:0];
            result.entry.memory = (mem_sum > (MEM_W+1)'(MEMORY_CAPACITY))
                                ? MEM_W'(MEMORY_CAPACITY) : mem_sum[MEM_W-1:0];
        end
        else
        begin
            result.entry.cores  = entry.cores - cores;
            result.entry.memory = entry.memory - memory;
        end
    end

endmodule

@@ design/first_fit_two_resource_allocator.sv @@
// ============================================================================
// first_fit_two_resource_allocator: first-fit core and memory allocator
// node table in a ram, scanned one entry per cycle by a shared compare unit
// ============================================================================
//
//  channel   signals                  direction  handshake
//  -------   -----------------------  ---------  ------------------------------
//  request   start, busy, req         in         taken when start && !busy
//  result    done, rsp                out        one-cycle strobe, no stall
//  config    cfg_we, cfg_wdata        in         written when cfg_we
//
//  after reset a clearing pass writes every node to full capacity with busy high
//  allocate scans from node 0 and stops at the first node that fits;
//  no fit: all count nodes are checked, count being min(nodes_in_use, NODES)
//  release reads then writes the named node; out-of-range release or empty node set is answered from idle
//  the scan rate is set by the single read port of the node ram
//  results cannot be held off: done pulses for one cycle with rsp valid
//
module first_fit_two_resource_allocator
    import ffa_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  alloc_req_t       req,
    output logic             done,
    output alloc_rsp_t       rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // index into the node table and counter that can hold NODES itself
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int TGT_W  = (CNT_W > NODE_FIELD_W) ? CNT_W : NODE_FIELD_W;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_REL_RD = 5'b01000,
        S_REL_WR = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] nodes_in_use_reg;
    alloc_req_t       req_reg, req_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [NODE_W-1:0] chk_idx_reg, chk_idx_next;
    logic             done_reg, done_next;
    alloc_rsp_t       rsp_reg, rsp_next;

    // effective node count and checks
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] count;
    logic             target_out;
    logic             issue_ok;

    // ram ports
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    ffa_entry_t        ram_wdata;
    logic [NODE_W-1:0] ram_raddr;
    ffa_entry_t        ram_rdata;
    logic [NODE_W-1:0] tgt_idx;
    ffa_entry_t        full_entry;

    ffa_alu_out_t      alu_out;

    assign cfg_ext    = CMP_W'(nodes_in_use_reg);
    assign count      = (cfg_ext > CMP_W'(NODES)) ? CNT_W'(NODES) : CNT_W'(cfg_ext);
    // range check uses the live request at accept time
    assign target_out = TGT_W'(req.target_node) >= TGT_W'(count);
    assign issue_ok   = scan_reg < count;
    assign tgt_idx    = NODE_W'(req_reg.target_node);

    assign full_entry.cores  = CORE_W'(CORE_CAPACITY);
    assign full_entry.memory = MEM_W'(MEMORY_CAPACITY);

    // scan reads walk the table, release reads the named node
    assign ram_raddr = (state_reg == S_SCAN) ? scan_reg[NODE_W-1:0] : tgt_idx;

    ffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one compare/update unit shared by allocate and release
    ffa_alu u_alu (
        .entry      (ram_rdata),
        .release_op (state_reg == S_REL_WR),
        .cores      (req_reg.cores_wanted),
        .memory     (req_reg.memory_wanted),
        .result     (alu_out)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        clr_next       = clr_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = tgt_idx;
        ram_wdata      = alu_out.entry;

        unique case (state_reg)
            S_CLEAR:
            begin
                // fill every node with full capacity
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = full_entry;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == NODE_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (count == '0)
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{status: STATUS_NO_FIT, default: '0};
                        end
                        else
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (target_out)
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{status: STATUS_RANGE, default: '0};
                        end
                        else
                        begin
                            state_next = S_REL_RD;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // issue next read while checking the one that returned
                chk_valid_next = issue_ok;
                chk_idx_next   = scan_reg[NODE_W-1:0];
                scan_next      = issue_ok ? scan_reg + 1'b1 : scan_reg;
                if (chk_valid_reg && alu_out.fit)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    done_next      = 1'b1;
                    rsp_next.status      = STATUS_DONE;
                    rsp_next.chosen_node = NODE_FIELD_W'(chk_idx_reg);
                    rsp_next.cores_left  = alu_out.entry.cores;
                    rsp_next.memory_left = alu_out.entry.memory;
                    state_next = S_IDLE;
                end
                else if (!chk_valid_reg && !issue_ok)
                begin
                    // every node checked, none fits
                    done_next  = 1'b1;
                    rsp_next   = '{status: STATUS_NO_FIT, default: '0};
                    state_next = S_IDLE;
                end
            end
            S_REL_RD:
            begin
                // target entry read in flight
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                ram_we    = 1'b1;
                done_next = 1'b1;
                rsp_next.status      = STATUS_DONE;
                rsp_next.chosen_node = req_reg.target_node;
                rsp_next.cores_left  = alu_out.entry.cores;
                rsp_next.memory_left = alu_out.entry.memory;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            nodes_in_use_reg <= CFG_RESET;
            clr_reg          <= '0;
            scan_reg         <= '0;
            chk_valid_reg    <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                nodes_in_use_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        chk_idx_reg <= chk_idx_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    // rejected requests carry an all-zero payload
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != STATUS_DONE) |->
            (rsp.chosen_node == '0) && (rsp.cores_left == '0) && (rsp.memory_left == '0))
        else $error("rejected result with nonzero payload");

    // the table is never written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("table write while idle");

    // a completed operation never leaves a node above capacity
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == STATUS_DONE) |->
            (rsp.cores_left <= CORE_W'(CORE_CAPACITY))
            && (rsp.memory_left <= MEM_W'(MEMORY_CAPACITY)))
        else $error("node left above capacity");

    // a pending check only follows a scan cycle
    a_chk_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == S_SCAN) && $past(state_reg == S_SCAN))
        else $error("check pending outside scan");
`endif

endmodule

@@ verif/ffa_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffa_checker: request and result monitor for the first-fit allocator
// keeps its own copy of the node table and node count, predicts the result
// of every accepted request and compares it field by field with the result
// ============================================================================
module ffa_checker
    import ffa_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  alloc_req_t       req,
    input  logic             done,
    input  alloc_rsp_t       rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               error_count,
    output int               grants_waiting
);

    int         spare_cores [NODES];
    int         spare_memory [NODES];
    int         node_limit;
    alloc_rsp_t grants_due [$];
    int         mismatches = 0;
    int         waiting = 0;

    assign error_count    = mismatches;
    assign grants_waiting = waiting;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // first fit over the nodes taking part, or a saturating release; a release past them is out of range
    function automatic alloc_rsp_t place_request(input alloc_req_t r);
        alloc_rsp_t g;
        int         active;
        int         n;
        bit         placed;
        g      = '0;
        placed = 1'b0;
        active = (node_limit > NODES) ? NODES : node_limit;
        if (r.cmd == CMD_ALLOC)
        begin
            g.status = STATUS_NO_FIT;
            for (n = 0; n < active; n++)
            begin
                if (!placed && spare_cores[n] >= int'(r.cores_wanted)
                    && spare_memory[n] >= int'(r.memory_wanted))
                begin
                    spare_cores[n]  -= int'(r.cores_wanted);
                    spare_memory[n] -= int'(r.memory_wanted);
                    g.status      = STATUS_DONE;
                    g.chosen_node = NODE_FIELD_W'(n);
                    g.cores_left  = CORE_W'(spare_cores[n]);
                    g.memory_left = MEM_W'(spare_memory[n]);
                    placed        = 1'b1;
                end
            end
        end
        else if (int'(r.target_node) >= active)
        begin
            g.status = STATUS_RANGE;
        end
        else
        begin
            n = int'(r.target_node);
            spare_cores[n]  += int'(r.cores_wanted);
            spare_memory[n] += int'(r.memory_wanted);
            if (spare_cores[n] > CORE_CAPACITY)
            begin
                spare_cores[n] = CORE_CAPACITY;
            end
            if (spare_memory[n] > MEMORY_CAPACITY)
            begin
                spare_memory[n] = MEMORY_CAPACITY;
            end
            g.status      = STATUS_DONE;
            g.chosen_node = NODE_FIELD_W'(n);
            g.cores_left  = CORE_W'(spare_cores[n]);
            g.memory_left = MEM_W'(spare_memory[n]);
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_rsp_t want;
        int         k;
        if (!rst_n)
        begin
            for (k = 0; k < NODES; k++)
            begin
                spare_cores[k]  = CORE_CAPACITY;
                spare_memory[k] = MEMORY_CAPACITY;
            end
            node_limit = int'(CFG_RESET);
            grants_due.delete();
        end
        else
        begin
            // results first: a result never belongs to a request taken at the same edge
            if (done === 1'b1)
            begin
                if (grants_due.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.chosen_node !== want.chosen_node)
                        report_mismatch($sformatf("chosen_node %0d, expected %0d",
                                                  rsp.chosen_node, want.chosen_node));
                    if (rsp.cores_left !== want.cores_left)
                        report_mismatch($sformatf("cores_left %0d, expected %0d",
                                                  rsp.cores_left, want.cores_left));
                    if (rsp.memory_left !== want.memory_left)
                        report_mismatch($sformatf("memory_left %0d, expected %0d",
                                                  rsp.memory_left, want.memory_left));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                grants_due.insert(grants_due.size(), place_request(req));
            end
            if (cfg_we === 1'b1)
            begin
                node_limit = int'(cfg_wdata);
            end
        end
        waiting = grants_due.size();
    end

endmodule

@@ verif/first_fit_two_resource_allocator_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// first_fit_two_resource_allocator_test: testbench for the first-fit allocator
// directed corner requests, then random allocate and release traffic over a
// series of node counts; the checker beside the block judges every result
// ============================================================================
module first_fit_two_resource_allocator_test;
    import ffa_pkg::*;

    localparam int NODE_COUNT  = NODES_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 50;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    alloc_req_t       req = '0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             busy;
    logic             done;
    alloc_rsp_t       rsp;
    int               error_count;
    int               grants_waiting;
    int               cycles = 0;
    int               node_count_now = int'(CFG_RESET);

    // node counts visited by the random phases: small tables fill up and
    // refill quickly, the large ones and the oversize values cover the clamp
    int phase_counts [10] = '{4, 1, 2, 255, 8, 0, 3, 16, 128, 5};

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    first_fit_two_resource_allocator #(
        .NODES(NODE_COUNT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    ffa_checker #(
        .NODES(NODE_COUNT)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .grants_waiting(grants_waiting)
    );

    // watchdog on a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // drive one request from a falling edge and hold it until taken;
    // busy is read at the rising edge, before the block updates it
    task automatic send_request(input logic cmd, input int target,
                                input int cores, input int mem);
        req.cmd           = cmd;
        req.target_node   = NODE_FIELD_W'(target);
        req.cores_wanted  = CORE_W'(cores);
        req.memory_wanted = MEM_W'(mem);
        start             = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // lower start for a number of cycles
    task automatic pause(input int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // mostly back to back or short, now and then a long hole
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // the node count changes only with nothing in flight
    task automatic write_node_count(input int value);
        start = 1'b0;
        while (grants_waiting != 0 || busy !== 1'b0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = CFG_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
        node_count_now = value;
    endtask

    // one random request; sizes are mostly moderate so that nodes fill up
    // and get split, with some past capacity and some at full field width
    task automatic random_request();
        int active;
        int r;
        int q;
        int target;
        int cores;
        int mem;
        active = (node_count_now > NODE_COUNT) ? NODE_COUNT : node_count_now;
        r      = $urandom_range(0, 99);
        q      = $urandom_range(0, 9);
        target = $urandom_range(0, 127);
        if (q < 6)
        begin
            cores = $urandom_range(0, 12);
            mem   = $urandom_range(0, 32);
        end
        else if (q < 9)
        begin
            cores = $urandom_range(0, CORE_CAPACITY);
            mem   = $urandom_range(0, MEMORY_CAPACITY);
        end
        else
        begin
            cores = $urandom_range(0, 31);
            mem   = $urandom_range(0, 127);
        end
        if (r < 55)
        begin
            send_request(CMD_ALLOC, target, cores, mem);
        end
        else
        begin
            // most releases name a node that takes part
            if (active > 0 && $urandom_range(0, 9) < 8)
                target = $urandom_range(0, active - 1);
            send_request(CMD_RELEASE, target, cores, mem);
        end
    endtask

    initial
    begin
        int p;
        int i;
        bit steady;

        // hold reset, then release it; the clearing pass afterwards shows as busy
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all nodes take part after reset
        send_request(CMD_ALLOC, 0, 0, 0);       // empty request, node 0 unchanged
        send_request(CMD_ALLOC, 99, 24, 64);    // drains node 0, target ignored
        send_request(CMD_ALLOC, 0, 1, 1);       // node 0 empty, lands on node 1
        send_request(CMD_ALLOC, 0, 25, 0);      // cores above capacity, no fit
        send_request(CMD_ALLOC, 0, 0, 65);      // memory above capacity, no fit
        send_request(CMD_ALLOC, 0, 31, 127);    // field maxima, no fit
        send_request(CMD_RELEASE, 0, 31, 127);  // saturates node 0 at capacity
        send_request(CMD_RELEASE, 127, 0, 0);   // last node, nothing returned
        send_request(CMD_RELEASE, 1, 1, 0);     // partial return to node 1

        // no node takes part
        write_node_count(0);
        send_request(CMD_ALLOC, 0, 0, 0);
        send_request(CMD_RELEASE, 0, 0, 0);

        // single node
        write_node_count(1);
        send_request(CMD_ALLOC, 0, 24, 64);
        send_request(CMD_ALLOC, 0, 1, 0);       // the only node is empty
        send_request(CMD_RELEASE, 1, 5, 5);     // just past the last node
        send_request(CMD_RELEASE, 0, 12, 32);

        // counts above the table size clamp to it
        write_node_count(200);
        send_request(CMD_RELEASE, 127, 3, 3);
        send_request(CMD_ALLOC, 0, 0, 0);
        write_node_count(255);
        send_request(CMD_RELEASE, 127, 31, 127);
        send_request(CMD_ALLOC, 5, 24, 64);

        // random phases, each under its own node count; some run without holes
        for (p = 0; p < 10; p++)
        begin
            write_node_count(phase_counts[p]);
            steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                random_request();
                if (!steady)
                begin
                    pause(gap_len());
                end
            end
        end

        // drain, then give the block time to show any stray result
        start = 1'b0;
        while (grants_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (NODE_COUNT + 10) @(negedge clk);

        if (error_count == 0 && grants_waiting == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
